// File: src/assert_macros.svh
// Assertion macros shared by the D2Q9 collision RTL.
// Included by the top level; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, switched off during reset.
`define D2Q9_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("D2Q9 collision assertion failed");

// Same-cycle implication built on the plain check.
`define D2Q9_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    `D2Q9_ASSERT(lbl, clk, rst_n, (ante) |-> (cons))

`endif

// File: src/d2q9_pkg.sv
// Types, constants and fixed-point helpers for the D2Q9 BGK collision pipeline.
// Self-contained; used by d2q9_bgk_cell_collision.
package d2q9_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 28;
    localparam int WIDE_BITS = WORD_BITS + 8;
    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int NDIR      = 9;
    localparam int NMOM      = 3;
    // Quotient bits of the velocity divider and numerator bits fed in during its steps.
    localparam int QBITS     = WORD_BITS - 1;
    localparam int NPRE      = WORD_BITS - 1 - FRAC_BITS;

    localparam int RATE_BITS = 30;
    localparam int MIN_BITS  = 31;
    localparam int CFG_BITS  = 31;
    localparam int IN_BITS   = NDIR * WORD_BITS;
    localparam int OUT_BITS  = (NDIR + NMOM) * WORD_BITS;

    // Configuration register indexes.
    localparam logic CFG_RATE     = 1'b0;
    localparam logic CFG_MIN_DENS = 1'b1;

    typedef logic signed [WORD_BITS-1:0] t_word;
    typedef logic signed [WIDE_BITS-1:0] t_wide;
    typedef logic signed [PROD_BITS-1:0] t_prod;
    typedef logic signed [WORD_BITS:0]   t_diff;
    typedef t_word [NDIR-1:0]            t_dist;

    localparam t_word W_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam t_word W_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
    localparam t_word ONE_Q = t_word'(64'd1 << FRAC_BITS);

    localparam logic [RATE_BITS-1:0] RATE_RESET = RATE_BITS'(64'd1 << FRAC_BITS);
    localparam logic [MIN_BITS-1:0]  MIN_RESET  = MIN_BITS'(1);

    // Lattice weights rounded to nearest at FRAC_BITS.
    localparam t_word W_REST = t_word'(((64'd4 << FRAC_BITS) + 64'd4) / 64'd9);
    localparam t_word W_AXIS = t_word'(((64'd1 << FRAC_BITS) + 64'd4) / 64'd9);
    localparam t_word W_DIAG = t_word'(((64'd1 << FRAC_BITS) + 64'd18) / 64'd36);

    // Direction components and weight class per population.
    localparam logic signed [1:0] DIR_X [NDIR] =
        '{2'sd0, 2'sd1, 2'sd0, -2'sd1, 2'sd0, 2'sd1, -2'sd1, -2'sd1, 2'sd1};
    localparam logic signed [1:0] DIR_Y [NDIR] =
        '{2'sd0, 2'sd0, 2'sd1, 2'sd0, -2'sd1, 2'sd1, 2'sd1, -2'sd1, -2'sd1};
    localparam logic [1:0] WCLS [NDIR] =
        '{2'd0, 2'd1, 2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2};

    // One lane of the restoring divider.
    typedef struct packed {
        logic [WORD_BITS-1:0] rem;
        logic [QBITS-1:0]     q;
        logic [NPRE-1:0]      nlo;
        logic                 neg;
        logic                 ovf;
    } t_divlane;

    // Cell data travelling beside the divider.
    typedef struct packed {
        t_dist f;
        t_word rho;
        logic  low;
    } t_divcarry;

    typedef struct packed {
        t_word rho;
        t_word ux;
        t_word uy;
    } t_moments;

    // Sign extension of a word to the wide accumulator.
    function automatic t_wide sx(t_word w);
        return {{(WIDE_BITS-WORD_BITS){w[WORD_BITS-1]}}, w};
    endfunction

    // Saturation of a wide value to the word range.
    function automatic t_word sat_w(t_wide v);
        t_word r;
        if (v > sx(W_MAX)) begin
            r = W_MAX;
        end else if (v < sx(W_MIN)) begin
            r = W_MIN;
        end else begin
            r = v[WORD_BITS-1:0];
        end
        return r;
    endfunction

    // Rounds a full product to FRAC_BITS, ties away from zero, then saturates.
    function automatic t_word qround(t_prod p);
        logic [PROD_BITS-1:0] mag;
        logic [PROD_BITS-1:0] m;
        t_word r;
        mag = p[PROD_BITS-1] ? (PROD_BITS'(0) - p) : p;
        m   = (mag + (PROD_BITS'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (p[PROD_BITS-1]) begin
            if (m >= (PROD_BITS'(1) << (WORD_BITS - 1))) r = W_MIN;
            else r = t_word'(WORD_BITS'(0) - m[WORD_BITS-1:0]);
        end else begin
            if (m >= (PROD_BITS'(1) << (WORD_BITS - 1))) r = W_MAX;
            else r = m[WORD_BITS-1:0];
        end
        return r;
    endfunction

    // Loads the divider: magnitude of the momentum, overflow test against the density.
    function automatic t_divlane div_setup(t_word m, t_word d);
        logic [WORD_BITS-1:0] n;
        t_divlane s;
        n     = m[WORD_BITS-1] ? (WORD_BITS'(0) - m) : m;
        s.neg = m[WORD_BITS-1];
        s.ovf = {{NPRE{1'b0}}, n} >= {d, {NPRE{1'b0}}};
        s.rem = n >> NPRE;
        s.nlo = n[NPRE-1:0];
        s.q   = '0;
        return s;
    endfunction

    // Numerator bit brought down at divider step k.
    function automatic logic div_nbit(logic [NPRE-1:0] nlo, int k);
        int   b;
        logic r;
        b = QBITS - k;
        r = 1'b0;
        if (b >= FRAC_BITS) r = nlo[b-FRAC_BITS];
        return r;
    endfunction

    // One restoring step: shift in a bit, subtract the density where it fits.
    function automatic t_divlane div_step(t_divlane s, logic [WORD_BITS-1:0] d, logic nbit);
        logic [WORD_BITS:0] t;
        logic [WORD_BITS:0] dif;
        t_divlane o;
        o   = s;
        t   = {s.rem, nbit};
        dif = t - {1'b0, d};
        if (t >= {1'b0, d}) begin
            o.rem = dif[WORD_BITS-1:0];
            o.q   = {s.q[QBITS-2:0], 1'b1};
        end else begin
            o.rem = t[WORD_BITS-1:0];
            o.q   = {s.q[QBITS-2:0], 1'b0};
        end
        return o;
    endfunction

    // Rounds the quotient on the remainder and applies sign and saturation.
    function automatic t_word div_finish(t_divlane s, logic [WORD_BITS-1:0] d);
        logic [WORD_BITS:0] q;
        logic               rup;
        t_word              r;
        rup = {s.rem, 1'b0} >= {1'b0, d};
        q   = {2'b00, s.q} + (WORD_BITS+1)'(rup);
        if (s.ovf) begin
            r = s.neg ? W_MIN : W_MAX;
        end else if (q >= (WORD_BITS+1)'(64'd1 << (WORD_BITS - 1))) begin
            r = s.neg ? W_MIN : W_MAX;
        end else if (s.neg) begin
            r = t_word'(WORD_BITS'(0) - q[WORD_BITS-1:0]);
        end else begin
            r = q[WORD_BITS-1:0];
        end
        return r;
    endfunction

endpackage

// File: src/d2q9_bgk_cell_collision.sv
// D2Q9 BGK collision of one lattice cell, fully pipelined in Q3.28 fixed point.
// Depends on d2q9_pkg and assert_macros.svh.
//
//   Channel   Dir  Handshake                     Content
//   s_axis    in   s_axis_tvalid/s_axis_tready   nine populations of one cell
//   m_axis    out  m_axis_tvalid/m_axis_tready   nine relaxed populations, density, velocity
//   cfg       in   i_cfg_we                      relaxation rate, minimum density
//
// One cell enters per clock while no waiting result holds the pipeline; each cell passes the sums,
// the velocity divider and stages A to I. The divider yields one quotient bit per stage (31 stages).
// Reset is synchronous; it clears the valid bits and sets the configuration registers to their reset values.
// A waiting result halts every stage together, so nothing is lost or repeated.
`include "assert_macros.svh"

module d2q9_bgk_cell_collision (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [d2q9_pkg::CFG_BITS-1:0] i_cfg_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // dist_rest, dist_east, dist_north, dist_west, dist_south, dist_ne, dist_nw,
    // dist_sw, dist_se, 32 bits each from the lowest bit up
    input  logic [d2q9_pkg::IN_BITS-1:0]  s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // new_rest, new_east, new_north, new_west, new_south, new_ne, new_nw, new_sw,
    // new_se, density, vel_x, vel_y, 32 bits each from the lowest bit up
    output logic [d2q9_pkg::OUT_BITS-1:0] m_axis_tdata
);

    localparam int QB  = d2q9_pkg::QBITS;
    localparam int NST = 2 + QB + 9;
    localparam int ND  = d2q9_pkg::NDIR;

    logic [d2q9_pkg::RATE_BITS-1:0] r_rate;
    logic [d2q9_pkg::MIN_BITS-1:0]  r_min_dens;
    logic [NST-1:0]                 r_vld;
    logic                           w_adv;

    // Stage 1: sums
    d2q9_pkg::t_dist r_s1_f;
    d2q9_pkg::t_word r_s1_rho, r_s1_mx, r_s1_my;
    logic            r_s1_low;
    d2q9_pkg::t_word n_s1_rho, n_s1_mx, n_s1_my;
    logic            n_s1_low;

    // Divider
    d2q9_pkg::t_divlane  r_dx [QB+1];
    d2q9_pkg::t_divlane  r_dy [QB+1];
    d2q9_pkg::t_divcarry r_dc [QB+1];
    d2q9_pkg::t_divlane  n_dx [QB+1];
    d2q9_pkg::t_divlane  n_dy [QB+1];
    d2q9_pkg::t_divcarry n_dc [QB+1];

    // Delay lines beside the equilibrium stages
    d2q9_pkg::t_moments r_mom [9];
    d2q9_pkg::t_dist    r_fl  [8];
    d2q9_pkg::t_moments n_a_mom;

    // Stages B to I
    d2q9_pkg::t_dist r_b_cu, n_b_cu;
    d2q9_pkg::t_prod r_b_pxx, r_b_pyy, n_b_pxx, n_b_pyy;
    d2q9_pkg::t_prod r_b_prw [3];
    d2q9_pkg::t_prod n_b_prw [3];
    d2q9_pkg::t_dist r_c_cu;
    d2q9_pkg::t_word r_c_u2, n_c_u2;
    d2q9_pkg::t_word r_c_rw [3];
    d2q9_pkg::t_word n_c_rw [3];
    d2q9_pkg::t_prod r_c_pcu2 [ND];
    d2q9_pkg::t_prod n_c_pcu2 [ND];
    d2q9_pkg::t_dist r_d_cu, r_d_cu2, n_d_cu2;
    d2q9_pkg::t_word r_d_u2;
    d2q9_pkg::t_word r_d_rw [3];
    d2q9_pkg::t_dist r_e_poly, n_e_poly;
    d2q9_pkg::t_word r_e_rw [3];
    d2q9_pkg::t_prod r_f_pfeq [ND];
    d2q9_pkg::t_prod n_f_pfeq [ND];
    d2q9_pkg::t_diff r_g_diff [ND];
    d2q9_pkg::t_diff n_g_diff [ND];
    d2q9_pkg::t_prod r_h_prel [ND];
    d2q9_pkg::t_prod n_h_prel [ND];
    d2q9_pkg::t_dist r_i_new, n_i_new;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate     <= d2q9_pkg::RATE_RESET;
            r_min_dens <= d2q9_pkg::MIN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                d2q9_pkg::CFG_RATE:     r_rate     <= i_cfg_data[d2q9_pkg::RATE_BITS-1:0];
                d2q9_pkg::CFG_MIN_DENS: r_min_dens <= i_cfg_data[d2q9_pkg::MIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // The whole pipeline moves when the output word is empty or being taken.
    assign w_adv         = !r_vld[NST-1] || m_axis_tready;
    assign s_axis_tready = w_adv;
    assign m_axis_tvalid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NST-2:0], s_axis_tvalid};
        end
    end

    // Density and momentum sums with the low-density test.
    always_comb begin
        d2q9_pkg::t_dist f;
        d2q9_pkg::t_wide acc_r, acc_x, acc_y;
        f     = d2q9_pkg::t_dist'(s_axis_tdata);
        acc_r = '0;
        acc_x = '0;
        acc_y = '0;
        for (int i = 0; i < ND; i++) begin
            acc_r = acc_r + d2q9_pkg::sx(f[i]);
            if (d2q9_pkg::DIR_X[i] == 2'sd1) acc_x = acc_x + d2q9_pkg::sx(f[i]);
            if (d2q9_pkg::DIR_X[i] == -2'sd1) acc_x = acc_x - d2q9_pkg::sx(f[i]);
            if (d2q9_pkg::DIR_Y[i] == 2'sd1) acc_y = acc_y + d2q9_pkg::sx(f[i]);
            if (d2q9_pkg::DIR_Y[i] == -2'sd1) acc_y = acc_y - d2q9_pkg::sx(f[i]);
        end
        n_s1_rho = d2q9_pkg::sat_w(acc_r);
        n_s1_mx  = d2q9_pkg::sat_w(acc_x);
        n_s1_my  = d2q9_pkg::sat_w(acc_y);
        n_s1_low = n_s1_rho[d2q9_pkg::WORD_BITS-1] || (n_s1_rho == '0) ||
                   (n_s1_rho[d2q9_pkg::MIN_BITS-1:0] < r_min_dens);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_f   <= d2q9_pkg::t_dist'(s_axis_tdata);
            r_s1_rho <= n_s1_rho;
            r_s1_mx  <= n_s1_mx;
            r_s1_my  <= n_s1_my;
            r_s1_low <= n_s1_low;
        end
    end

    // Velocity divider: setup stage, then one quotient bit per stage.
    always_comb begin
        n_dx[0]     = d2q9_pkg::div_setup(r_s1_mx, r_s1_rho);
        n_dy[0]     = d2q9_pkg::div_setup(r_s1_my, r_s1_rho);
        n_dc[0].f   = r_s1_f;
        n_dc[0].rho = r_s1_rho;
        n_dc[0].low = r_s1_low;
        for (int k = 1; k <= QB; k++) begin
            n_dx[k] = d2q9_pkg::div_step(r_dx[k-1], r_dc[k-1].rho,
                                         d2q9_pkg::div_nbit(r_dx[k-1].nlo, k));
            n_dy[k] = d2q9_pkg::div_step(r_dy[k-1], r_dc[k-1].rho,
                                         d2q9_pkg::div_nbit(r_dy[k-1].nlo, k));
            n_dc[k] = r_dc[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dx <= n_dx;
            r_dy <= n_dy;
            r_dc <= n_dc;
        end
    end

    // Stage A: round the quotients; a low density forces the moments to zero.
    always_comb begin
        if (r_dc[QB].low) begin
            n_a_mom = '0;
        end else begin
            n_a_mom.rho = r_dc[QB].rho;
            n_a_mom.ux  = d2q9_pkg::div_finish(r_dx[QB], r_dc[QB].rho);
            n_a_mom.uy  = d2q9_pkg::div_finish(r_dy[QB], r_dc[QB].rho);
        end
    end

    // Stage B: projections c.u and the products u*u and rho*w.
    always_comb begin
        d2q9_pkg::t_wide cx, cy;
        for (int i = 0; i < ND; i++) begin
            cx = '0;
            cy = '0;
            if (d2q9_pkg::DIR_X[i] == 2'sd1) cx = d2q9_pkg::sx(r_mom[0].ux);
            if (d2q9_pkg::DIR_X[i] == -2'sd1) cx = -d2q9_pkg::sx(r_mom[0].ux);
            if (d2q9_pkg::DIR_Y[i] == 2'sd1) cy = d2q9_pkg::sx(r_mom[0].uy);
            if (d2q9_pkg::DIR_Y[i] == -2'sd1) cy = -d2q9_pkg::sx(r_mom[0].uy);
            n_b_cu[i] = d2q9_pkg::sat_w(cx + cy);
        end
        n_b_pxx    = r_mom[0].ux * r_mom[0].ux;
        n_b_pyy    = r_mom[0].uy * r_mom[0].uy;
        n_b_prw[0] = r_mom[0].rho * d2q9_pkg::W_REST;
        n_b_prw[1] = r_mom[0].rho * d2q9_pkg::W_AXIS;
        n_b_prw[2] = r_mom[0].rho * d2q9_pkg::W_DIAG;
    end

    // Stage C: u.u and the weighted densities; squares of c.u.
    always_comb begin
        n_c_u2 = d2q9_pkg::sat_w(d2q9_pkg::sx(d2q9_pkg::qround(r_b_pxx)) +
                                 d2q9_pkg::sx(d2q9_pkg::qround(r_b_pyy)));
        for (int k = 0; k < 3; k++) n_c_rw[k] = d2q9_pkg::qround(r_b_prw[k]);
        for (int i = 0; i < ND; i++) n_c_pcu2[i] = r_b_cu[i] * r_b_cu[i];
    end

    // Stage D: round the squares.
    always_comb begin
        for (int i = 0; i < ND; i++) n_d_cu2[i] = d2q9_pkg::qround(r_c_pcu2[i]);
    end

    // Stage E: polynomial 1 + 3cu + (9cu^2 - 3u.u)/2, halving rounded away from zero.
    always_comb begin
        d2q9_pkg::t_wide v, mag, h, c3;
        for (int i = 0; i < ND; i++) begin
            v   = ((d2q9_pkg::sx(r_d_cu2[i]) <<< 3) + d2q9_pkg::sx(r_d_cu2[i])) -
                  ((d2q9_pkg::sx(r_d_u2) <<< 1) + d2q9_pkg::sx(r_d_u2));
            mag = v[d2q9_pkg::WIDE_BITS-1] ? -v : v;
            mag = (mag + d2q9_pkg::t_wide'(1)) >>> 1;
            h   = v[d2q9_pkg::WIDE_BITS-1] ? -mag : mag;
            c3  = (d2q9_pkg::sx(r_d_cu[i]) <<< 1) + d2q9_pkg::sx(r_d_cu[i]);
            n_e_poly[i] = d2q9_pkg::sat_w(d2q9_pkg::sx(d2q9_pkg::ONE_Q) + c3 + h);
        end
    end

    // Stage F: equilibrium product.
    always_comb begin
        for (int i = 0; i < ND; i++) begin
            n_f_pfeq[i] = r_e_rw[d2q9_pkg::WCLS[i]] * r_e_poly[i];
        end
    end

    // Stage G: distance to equilibrium.
    always_comb begin
        d2q9_pkg::t_word feq;
        for (int i = 0; i < ND; i++) begin
            feq = d2q9_pkg::qround(r_f_pfeq[i]);
            n_g_diff[i] = {feq[d2q9_pkg::WORD_BITS-1], feq} -
                          {r_fl[5][i][d2q9_pkg::WORD_BITS-1], r_fl[5][i]};
        end
    end

    // Stage H: scale by the relaxation rate.
    always_comb begin
        for (int i = 0; i < ND; i++) begin
            n_h_prel[i] = $signed({1'b0, r_rate}) * r_g_diff[i];
        end
    end

    // Stage I: relaxed populations.
    always_comb begin
        for (int i = 0; i < ND; i++) begin
            n_i_new[i] = d2q9_pkg::sat_w(d2q9_pkg::sx(r_fl[7][i]) +
                                         d2q9_pkg::sx(d2q9_pkg::qround(r_h_prel[i])));
        end
    end

    // Stage registers A to I and the delay lines beside them.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_mom[0] <= n_a_mom;
            for (int k = 1; k < 9; k++) r_mom[k] <= r_mom[k-1];
            r_fl[0] <= r_dc[QB].f;
            for (int k = 1; k < 8; k++) r_fl[k] <= r_fl[k-1];
            r_b_cu   <= n_b_cu;
            r_b_pxx  <= n_b_pxx;
            r_b_pyy  <= n_b_pyy;
            r_b_prw  <= n_b_prw;
            r_c_cu   <= r_b_cu;
            r_c_u2   <= n_c_u2;
            r_c_rw   <= n_c_rw;
            r_c_pcu2 <= n_c_pcu2;
            r_d_cu   <= r_c_cu;
            r_d_cu2  <= n_d_cu2;
            r_d_u2   <= r_c_u2;
            r_d_rw   <= r_c_rw;
            r_e_poly <= n_e_poly;
            r_e_rw   <= r_d_rw;
            r_f_pfeq <= n_f_pfeq;
            r_g_diff <= n_g_diff;
            r_h_prel <= n_h_prel;
            r_i_new  <= n_i_new;
        end
    end

    assign m_axis_tdata = {r_mom[8].uy, r_mom[8].ux, r_mom[8].rho, r_i_new};

    // A waiting result holds back the input side.
    `D2Q9_ASSERT_IMPL(a_stall_blocks_input, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, !s_axis_tready)
    // A zero density comes only from the low-density path, which zeroes the velocity.
    `D2Q9_ASSERT_IMPL(a_zero_density_still, i_clk, i_rst_n, r_vld[NST-1] && (r_mom[8].rho == '0), (r_mom[8].ux == '0) && (r_mom[8].uy == '0))
    // A delivered density is never negative.
    `D2Q9_ASSERT_IMPL(a_density_positive, i_clk, i_rst_n, r_vld[NST-1], !r_mom[8].rho[d2q9_pkg::WORD_BITS-1])

endmodule
